[design/wssp_pkg.sv]
package wssp_pkg;

	localparam int SCREEN_CLAMP = 32000;
	localparam int NEAR_PLANE = 26;
	localparam int CQ = 28;
	localparam int PQ = 35;
	localparam int NLANE = 10;

	localparam logic [2:0] REG_CAM_X = 3'd0;
	localparam logic [2:0] REG_CAM_Y = 3'd1;
	localparam logic [2:0] REG_CAM_Z = 3'd2;
	localparam logic [2:0] REG_COS = 3'd3;
	localparam logic [2:0] REG_SIN = 3'd4;
	localparam logic [2:0] REG_HALF_W = 3'd5;
	localparam logic [2:0] REG_HALF_H = 3'd6;

	typedef enum logic [1:0] {
		KIND_SOLID = 2'd0,
		KIND_UPPER = 2'd1,
		KIND_LOWER = 2'd2,
		KIND_SPAN = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [24:0] fh;
		logic signed [24:0] ch;
		logic signed [24:0] nfh;
		logic signed [24:0] nch;
		logic portal;
		logic signed [15:0] cl;
		logic signed [15:0] cr;
	} side_t;

	typedef struct packed {
		logic near1;
		logic near2;
		logic signed [27:0] x1;
		logic signed [27:0] y1;
		logic signed [27:0] x2;
		logic signed [27:0] y2;
		side_t sd;
	} geo_t;

	typedef struct packed {
		logic cull;
		logic portal;
		logic up;
		logic low;
		logic signed [15:0] cl;
		logic signed [15:0] cr;
		logic [27:0] y1;
		logic [27:0] y2;
	} prj_t;

	typedef struct packed {
		kind_t kind;
		logic signed [15:0] xl;
		logic signed [15:0] xr;
		logic signed [15:0] tl;
		logic signed [15:0] bl;
		logic signed [15:0] tr;
		logic signed [15:0] br;
	} rec_t;

	function automatic logic signed [27:0] rot_div(input logic signed [41:0] s);
		logic signed [41:0] t;
		t = s + ((s < 0) ? 42'sd16383 : 42'sd0);
		return t[41:14];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v < -36'sd32768) begin
			r = -16'sd32768;
		end else if (v > 36'sd32767) begin
			r = 16'sd32767;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clampx(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v < -36'(SCREEN_CLAMP)) begin
			r = -16'(SCREEN_CLAMP);
		end else if (v > 36'(SCREEN_CLAMP)) begin
			r = 16'(SCREEN_CLAMP);
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[design/wall_segment_screen_projection.sv]
// Projects one wall item per clock onto the screen while the output does not stall. Each wall
// passes through six setup stages, a 29-stage restoring divider for the near-plane clip, two
// stages, a 36-stage bank of ten restoring dividers (two columns, eight rows), two finish
// stages and the output register. Every divider retires one quotient bit per stage, so a wall
// enters every cycle unless the output stalls. A portal wall with two or three results holds
// the input until its last is taken; the output hands out one result per cycle of out_ready.
module wall_segment_screen_projection (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic signed [23:0] start_x,
	input logic signed [23:0] start_y,
	input logic signed [23:0] end_x,
	input logic signed [23:0] end_y,
	input logic signed [23:0] floor_z,
	input logic signed [23:0] ceil_z,
	input logic is_portal,
	input logic signed [23:0] next_floor_z,
	input logic signed [23:0] next_ceil_z,
	input logic signed [15:0] clip_left,
	input logic signed [15:0] clip_right,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic signed [15:0] x_left,
	output logic signed [15:0] x_right,
	output logic signed [15:0] top_left,
	output logic signed [15:0] bottom_left,
	output logic signed [15:0] top_right,
	output logic signed [15:0] bottom_right,
	output logic last
);
	import wssp_pkg::*;

	logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [15:0] cos_q, sin_q;
	logic [11:0] hw_q, hh_q;
	logic signed [12:0] hws;
	logic adv;

	assign pready = 1'b1;
	assign hws = $signed({1'b0, hw_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			cos_q <= 16'sd16384;
			sin_q <= '0;
			hw_q <= 12'd160;
			hh_q <= 12'd100;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_CAM_X: cam_x_q <= pwdata[23:0];
				REG_CAM_Y: cam_y_q <= pwdata[23:0];
				REG_CAM_Z: cam_z_q <= pwdata[23:0];
				REG_COS: cos_q <= pwdata[15:0];
				REG_SIN: sin_q <= pwdata[15:0];
				REG_HALF_W: hw_q <= pwdata[11:0];
				REG_HALF_H: hh_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_CAM_X: prdata = 32'(cam_x_q);
			REG_CAM_Y: prdata = 32'(cam_y_q);
			REG_CAM_Z: prdata = 32'(cam_z_q);
			REG_COS: prdata = 32'(cos_q);
			REG_SIN: prdata = 32'(sin_q);
			REG_HALF_W: prdata = {20'd0, hw_q};
			REG_HALF_H: prdata = {20'd0, hh_q};
			default: prdata = '0;
		endcase
	end

	// Stage 1: offsets from the camera.
	logic v_s1;
	logic signed [24:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	side_t sd_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx1_s1 <= 25'(start_x) - 25'(cam_x_q);
			dy1_s1 <= 25'(start_y) - 25'(cam_y_q);
			dx2_s1 <= 25'(end_x) - 25'(cam_x_q);
			dy2_s1 <= 25'(end_y) - 25'(cam_y_q);
			sd_s1.fh <= 25'(floor_z) - 25'(cam_z_q);
			sd_s1.ch <= 25'(ceil_z) - 25'(cam_z_q);
			sd_s1.nfh <= 25'(next_floor_z) - 25'(cam_z_q);
			sd_s1.nch <= 25'(next_ceil_z) - 25'(cam_z_q);
			sd_s1.portal <= is_portal;
			sd_s1.cl <= clip_left;
			sd_s1.cr <= clip_right;
		end
	end

	// Stage 2: rotation products.
	logic v_s2;
	logic signed [40:0] pa1_s2, pb1_s2, pc1_s2, pd1_s2;
	logic signed [40:0] pa2_s2, pb2_s2, pc2_s2, pd2_s2;
	side_t sd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa1_s2 <= 41'(dx1_s1) * 41'(sin_q);
			pb1_s2 <= 41'(dy1_s1) * 41'(cos_q);
			pc1_s2 <= 41'(dx1_s1) * 41'(cos_q);
			pd1_s2 <= 41'(dy1_s1) * 41'(sin_q);
			pa2_s2 <= 41'(dx2_s1) * 41'(sin_q);
			pb2_s2 <= 41'(dy2_s1) * 41'(cos_q);
			pc2_s2 <= 41'(dx2_s1) * 41'(cos_q);
			pd2_s2 <= 41'(dy2_s1) * 41'(sin_q);
			sd_s2 <= sd_s1;
		end
	end

	// Stage 3: sums.
	logic v_s3;
	logic signed [41:0] sx1_s3, sy1_s3, sx2_s3, sy2_s3;
	side_t sd_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx1_s3 <= 42'(pa1_s2) - 42'(pb1_s2);
			sy1_s3 <= 42'(pc1_s2) + 42'(pd1_s2);
			sx2_s3 <= 42'(pa2_s2) - 42'(pb2_s2);
			sy2_s3 <= 42'(pc2_s2) + 42'(pd2_s2);
			sd_s3 <= sd_s2;
		end
	end

	// Stage 4: scale back to 8 fraction bits, truncating toward zero.
	logic v_s4;
	geo_t geo_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s4.near1 <= 1'b0;
			geo_s4.near2 <= 1'b0;
			geo_s4.x1 <= rot_div(sx1_s3);
			geo_s4.y1 <= rot_div(sy1_s3);
			geo_s4.x2 <= rot_div(sx2_s3);
			geo_s4.y2 <= rot_div(sy2_s3);
			geo_s4.sd <= sd_s3;
		end
	end

	// Stage 5: near-plane clip setup.
	logic v_s5;
	geo_t geo_s5, geo_c;
	logic signed [28:0] a_s5, b_s5, a_c, b_c;
	logic [28:0] d_s5, d_c;

	always_comb begin
		geo_c = geo_s4;
		geo_c.near1 = geo_s4.y1 <= 28'(NEAR_PLANE);
		geo_c.near2 = geo_s4.y2 <= 28'(NEAR_PLANE);
		if (geo_c.near1) begin
			a_c = 29'(geo_s4.x2) - 29'(geo_s4.x1);
			b_c = 29'(NEAR_PLANE) - 29'(geo_s4.y1);
			d_c = 29'(geo_s4.y2) - 29'(geo_s4.y1);
		end else if (geo_c.near2) begin
			a_c = 29'(geo_s4.x1) - 29'(geo_s4.x2);
			b_c = 29'(NEAR_PLANE) - 29'(geo_s4.y2);
			d_c = 29'(geo_s4.y1) - 29'(geo_s4.y2);
		end else begin
			a_c = '0;
			b_c = '0;
			d_c = 29'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s5 <= geo_c;
			a_s5 <= a_c;
			b_s5 <= b_c;
			d_s5 <= d_c;
		end
	end

	// Stage 6: clip numerator.
	logic v_s6;
	geo_t geo_s6;
	logic signed [57:0] prod_s6;
	logic [28:0] d_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s6 <= geo_s5;
			prod_s6 <= 58'(a_s5) * 58'(b_s5);
			d_s6 <= d_s5;
		end
	end

	// Clip divider, one quotient bit per stage.
	logic [63:0] crem_s [0:CQ];
	logic [CQ-1:0] cquo_s [0:CQ];
	logic [28:0] cdiv_s [0:CQ];
	logic cneg_s [0:CQ];
	geo_t cgeo_s [0:CQ];
	logic cv_s [0:CQ];

	always_ff @(posedge clk) begin
		if (adv) begin
			crem_s[0] <= 64'((prod_s6 < 0) ? -prod_s6 : prod_s6);
			cquo_s[0] <= '0;
			cdiv_s[0] <= d_s6;
			cneg_s[0] <= prod_s6 < 0;
			cgeo_s[0] <= geo_s6;
		end
	end

	for (genvar k = 1; k <= CQ; k++) begin : g_cdiv
		localparam int B = CQ - k;
		logic [63:0] sh;
		assign sh = 64'(cdiv_s[k-1]) << B;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (crem_s[k-1] >= sh) begin
					crem_s[k] <= crem_s[k-1] - sh;
					cquo_s[k] <= cquo_s[k-1] | (CQ'(1) << B);
				end else begin
					crem_s[k] <= crem_s[k-1];
					cquo_s[k] <= cquo_s[k-1];
				end
				cdiv_s[k] <= cdiv_s[k-1];
				cneg_s[k] <= cneg_s[k-1];
				cgeo_s[k] <= cgeo_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k] <= 1'b0;
			end else if (adv) begin
				cv_s[k] <= cv_s[k-1];
			end
		end
	end

	// Stage 7: move the near end onto the plane.
	logic v_s7;
	geo_t geo_s7, geo_k;
	logic signed [27:0] cq;

	always_comb begin
		geo_k = cgeo_s[CQ];
		cq = $signed(cquo_s[CQ]);
		if (geo_k.near1) begin
			geo_k.x1 = cneg_s[CQ] ? geo_k.x1 - cq : geo_k.x1 + cq;
			geo_k.y1 = 28'(NEAR_PLANE);
		end else if (geo_k.near2) begin
			geo_k.x2 = cneg_s[CQ] ? geo_k.x2 - cq : geo_k.x2 + cq;
			geo_k.y2 = 28'(NEAR_PLANE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s7 <= geo_k;
		end
	end

	// Stage 8: projection numerators.
	logic v_s8;
	logic signed [40:0] num_s8 [0:NLANE-1];
	prj_t prj_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s8[0] <= 41'(geo_s7.x1) * 41'(hws);
			num_s8[1] <= 41'(geo_s7.x2) * 41'(hws);
			num_s8[2] <= 41'(geo_s7.sd.ch) * 41'(hws);
			num_s8[3] <= 41'(geo_s7.sd.fh) * 41'(hws);
			num_s8[4] <= 41'(geo_s7.sd.nch) * 41'(hws);
			num_s8[5] <= 41'(geo_s7.sd.nfh) * 41'(hws);
			num_s8[6] <= 41'(geo_s7.sd.ch) * 41'(hws);
			num_s8[7] <= 41'(geo_s7.sd.fh) * 41'(hws);
			num_s8[8] <= 41'(geo_s7.sd.nch) * 41'(hws);
			num_s8[9] <= 41'(geo_s7.sd.nfh) * 41'(hws);
			prj_s8.cull <= geo_s7.near1 && geo_s7.near2;
			prj_s8.portal <= geo_s7.sd.portal;
			prj_s8.up <= geo_s7.sd.nch < geo_s7.sd.ch;
			prj_s8.low <= geo_s7.sd.nfh > geo_s7.sd.fh;
			prj_s8.cl <= geo_s7.sd.cl;
			prj_s8.cr <= geo_s7.sd.cr;
			prj_s8.y1 <= geo_s7.y1;
			prj_s8.y2 <= geo_s7.y2;
		end
	end

	// Projection divider bank: columns in lanes 0 and 1, rows in lanes 2 to 9.
	logic [63:0] prem_s [0:PQ][0:NLANE-1];
	logic [PQ-1:0] pquo_s [0:PQ][0:NLANE-1];
	logic pneg_s [0:PQ][0:NLANE-1];
	prj_t pctx_s [0:PQ];
	logic pv_s [0:PQ];

	for (genvar l = 0; l < NLANE; l++) begin : g_pload
		always_ff @(posedge clk) begin
			if (adv) begin
				prem_s[0][l] <= 64'((num_s8[l] < 0) ? -num_s8[l] : num_s8[l]);
				pquo_s[0][l] <= '0;
				pneg_s[0][l] <= num_s8[l] < 0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pctx_s[0] <= prj_s8;
		end
	end

	for (genvar k = 1; k <= PQ; k++) begin : g_pdiv
		localparam int B = PQ - k;

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			localparam bit ON_Y2 = (l == 1) || (l >= 6);
			logic [63:0] sh;
			assign sh = 64'(ON_Y2 ? pctx_s[k-1].y2 : pctx_s[k-1].y1) << B;

			always_ff @(posedge clk) begin
				if (adv) begin
					if (prem_s[k-1][l] >= sh) begin
						prem_s[k][l] <= prem_s[k-1][l] - sh;
						pquo_s[k][l] <= pquo_s[k-1][l] | (PQ'(1) << B);
					end else begin
						prem_s[k][l] <= prem_s[k-1][l];
						pquo_s[k][l] <= pquo_s[k-1][l];
					end
					pneg_s[k][l] <= pneg_s[k-1][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pctx_s[k] <= pctx_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s[k] <= 1'b0;
			end else if (adv) begin
				pv_s[k] <= pv_s[k-1];
			end
		end
	end

	// Stage 9: columns and saturated rows.
	logic v_s9;
	logic signed [35:0] sx_s9 [0:1];
	logic signed [15:0] row_s9 [0:7];
	prj_t ctx_s9;

	for (genvar l = 0; l < 2; l++) begin : g_col
		always_ff @(posedge clk) begin
			if (adv) begin
				sx_s9[l] <= pneg_s[PQ][l] ? 36'(hw_q) - 36'(pquo_s[PQ][l])
					: 36'(hw_q) + 36'(pquo_s[PQ][l]);
			end
		end
	end

	for (genvar l = 2; l < NLANE; l++) begin : g_row
		logic signed [35:0] rv;
		assign rv = pneg_s[PQ][l] ? 36'(hh_q) + 36'(pquo_s[PQ][l])
			: 36'(hh_q) - 36'(pquo_s[PQ][l]);

		always_ff @(posedge clk) begin
			if (adv) begin
				row_s9[l-2] <= sat16(rv);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s9 <= pctx_s[PQ];
		end
	end

	// Stage 10: equal-column test and clamping.
	logic v_s10;
	logic eq_s10;
	logic signed [15:0] cx1_s10, cx2_s10;
	logic signed [15:0] row_s10 [0:7];
	prj_t ctx_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			eq_s10 <= sx_s9[0] == sx_s9[1];
			cx1_s10 <= clampx(sx_s9[0]);
			cx2_s10 <= clampx(sx_s9[1]);
			row_s10 <= row_s9;
			ctx_s10 <= ctx_s9;
		end
	end

	// Result selection.
	logic vis, span_en;
	logic en0, en1, en2;
	logic signed [15:0] span_a, span_b;
	rec_t c0, c1, c2, slot0, slot1;
	logic [1:0] cnt_c;

	always_comb begin
		vis = !ctx_s10.cull && !eq_s10 && !(cx2_s10 < ctx_s10.cl || cx1_s10 > ctx_s10.cr);
		span_a = (cx1_s10 < ctx_s10.cl) ? ctx_s10.cl : cx1_s10;
		span_b = (cx2_s10 > ctx_s10.cr) ? ctx_s10.cr : cx2_s10;
		span_en = span_b > span_a;

		c0.xl = cx1_s10;
		c0.xr = cx2_s10;
		c1.xl = cx1_s10;
		c1.xr = cx2_s10;
		c1.kind = KIND_LOWER;
		c1.tl = row_s10[3];
		c1.bl = row_s10[1];
		c1.tr = row_s10[7];
		c1.br = row_s10[5];
		c2.kind = KIND_SPAN;
		c2.xl = span_a;
		c2.xr = span_b;
		c2.tl = '0;
		c2.bl = '0;
		c2.tr = '0;
		c2.br = '0;

		if (ctx_s10.portal) begin
			c0.kind = KIND_UPPER;
			c0.tl = row_s10[0];
			c0.bl = row_s10[2];
			c0.tr = row_s10[4];
			c0.br = row_s10[6];
			en0 = vis && ctx_s10.up;
			en1 = vis && ctx_s10.low;
			en2 = vis && span_en;
		end else begin
			c0.kind = KIND_SOLID;
			c0.tl = row_s10[0];
			c0.bl = row_s10[1];
			c0.tr = row_s10[4];
			c0.br = row_s10[5];
			en0 = vis;
			en1 = 1'b0;
			en2 = 1'b0;
		end

		slot0 = en0 ? c0 : (en1 ? c1 : c2);
		slot1 = (en0 && en1) ? c1 : c2;
		cnt_c = {1'b0, en0} + {1'b0, en1} + {1'b0, en2};
	end

	// Output register: holds the results of one wall and hands them out in order.
	rec_t rec_q [0:2];
	rec_t out_rec;
	logic [1:0] cnt_q, ptr_q;
	logic take;

	assign out_valid = ptr_q != cnt_q;
	assign last = (ptr_q + 2'd1) == cnt_q;
	assign take = out_valid && out_ready;
	assign adv = !out_valid || (take && last);
	assign in_ready = adv;
	assign out_rec = (ptr_q == 2'd2) ? rec_q[2] : ((ptr_q == 2'd1) ? rec_q[1] : rec_q[0]);

	assign kind = out_rec.kind;
	assign x_left = out_rec.xl;
	assign x_right = out_rec.xr;
	assign top_left = out_rec.tl;
	assign bottom_left = out_rec.bl;
	assign top_right = out_rec.tr;
	assign bottom_right = out_rec.br;

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_q[0] <= slot0;
			rec_q[1] <= slot1;
			rec_q[2] <= c2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (adv) begin
			cnt_q <= v_s10 ? cnt_c : 2'd0;
			ptr_q <= '0;
		end else if (take) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			cv_s[0] <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			pv_s[0] <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			cv_s[0] <= v_s6;
			v_s7 <= cv_s[CQ];
			v_s8 <= v_s7;
			pv_s[0] <= v_s8;
			v_s9 <= pv_s[PQ];
			v_s10 <= v_s9;
		end
	end

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= cnt_q)
		else $error("result pointer passed the result count");

	a_span_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rec.kind == KIND_SPAN |-> last)
		else $error("span item is not the final item of its wall");

	a_solid_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rec.kind == KIND_SOLID |-> last && cnt_q == 2'd1)
		else $error("solid wall produced more than one item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending output item");

endmodule
